### sv/pcs_pkg.sv
// ----------------------------------------------------------------------------
// pcs_pkg - shared types and arithmetic for the path corner smoother
// Point and product types, cell action codes and the corner-cut helpers.
// ----------------------------------------------------------------------------
package pcs_pkg;

    localparam int COORD_BITS = 32;
    localparam int NUM_AXES   = 3;
    localparam int MAX_PASSES = 2;
    localparam int CFG_W      = 2;
    localparam int PASS_W     = $clog2(MAX_PASSES + 1);

    // cut factor 14418/65536
    localparam int CUT_NUM   = 14418;
    localparam int CUT_SHIFT = 16;
    localparam int PROD_W    = COORD_BITS + CUT_SHIFT;

    localparam int DATA_W = ((NUM_AXES * COORD_BITS + 7) / 8) * 8;

    typedef logic [NUM_AXES-1:0][COORD_BITS-1:0] t_point;
    typedef logic [NUM_AXES-1:0][PROD_W-1:0]     t_prod;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_PASS,
        MODE_CUT
    } t_mode;

    // (o - c) * 14418, exact in PROD_W bits
    function automatic logic [PROD_W-1:0] cut_prod(
        input logic [COORD_BITS-1:0] o,
        input logic [COORD_BITS-1:0] c
    );
        logic signed [PROD_W-1:0] diff;
        logic signed [PROD_W-1:0] prod;
        diff = PROD_W'(signed'(o)) - PROD_W'(signed'(c));
        prod = diff * PROD_W'(CUT_NUM);
        return prod;
    endfunction

    // c + floor(prod / 65536); the arithmetic shift floors toward minus infinity
    function automatic logic [COORD_BITS-1:0] cut_apply(
        input logic [COORD_BITS-1:0] c,
        input logic [PROD_W-1:0]     prod
    );
        return c + prod[CUT_SHIFT +: COORD_BITS];
    endfunction

endpackage

### sv/pcs_cell.sv
// ----------------------------------------------------------------------------
// pcs_cell - one corner-cutting pass
// Holds a two-point window and forms both cut products on entry. Its output
// register emits up to three points per point taken, one per cycle unless stalled.
// ----------------------------------------------------------------------------
module pcs_cell
    import pcs_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_enable,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_point i_point,
    input  logic   i_last,
    output logic   o_valid,
    input  logic   i_ready,
    output t_point o_point,
    output logic   o_last
);

    // window
    logic [1:0] r_fill;
    logic [1:0] n_fill;
    t_point     r_prev;
    t_point     r_curr;
    logic       n_shift;

    // work register
    logic       r_p_valid;
    t_mode      r_mode;
    t_mode      n_mode;
    logic [1:0] r_step;
    t_point     r_pt;
    logic       r_pt_last;
    t_point     r_cv;
    t_prod      r_prod_a;
    t_prod      r_prod_b;

    // output register
    logic       r_out_valid;
    t_point     r_out_point;
    logic       r_out_last;

    t_point emit_pt;
    logic   emit_last;
    logic   emit_final;
    logic   has_emit;
    logic   out_free;
    logic   load;
    logic   p_done;
    logic   accept;

    always_comb begin
        emit_pt    = r_pt;
        emit_last  = r_pt_last;
        emit_final = 1'b1;
        unique case (r_mode)
            MODE_CUT: begin
                case (r_step)
                    2'd0: begin
                        for (int k = 0; k < NUM_AXES; k++) begin
                            emit_pt[k] = cut_apply(r_cv[k], r_prod_a[k]);
                        end
                        emit_last  = 1'b0;
                        emit_final = 1'b0;
                    end
                    2'd1: begin
                        for (int k = 0; k < NUM_AXES; k++) begin
                            emit_pt[k] = cut_apply(r_cv[k], r_prod_b[k]);
                        end
                        emit_last  = 1'b0;
                        emit_final = !r_pt_last;
                    end
                    default: begin
                        emit_pt    = r_pt;
                        emit_last  = 1'b1;
                        emit_final = 1'b1;
                    end
                endcase
            end
            MODE_PASS: begin
                emit_pt    = r_pt;
                emit_last  = r_pt_last;
                emit_final = 1'b1;
            end
            default: begin
                emit_pt    = r_pt;
                emit_last  = r_pt_last;
                emit_final = 1'b1;
            end
        endcase
    end

    assign has_emit = (r_mode != MODE_NONE);
    assign out_free = !r_out_valid || i_ready;
    assign load     = r_p_valid && has_emit && out_free;
    assign p_done   = r_p_valid && (!has_emit || (load && emit_final));
    assign o_ready  = !r_p_valid || p_done;
    assign accept   = i_valid && o_ready;

    // action and window update for the point being taken
    always_comb begin
        n_mode  = MODE_PASS;
        n_fill  = r_fill;
        n_shift = 1'b0;
        if (i_enable) begin
            unique case (r_fill)
                2'd0: begin
                    n_mode = MODE_PASS;
                    if (!i_last) begin
                        n_fill = 2'd1;
                    end
                end
                2'd1: begin
                    if (i_last) begin
                        n_mode = MODE_PASS;
                        n_fill = 2'd0;
                    end else begin
                        n_mode  = MODE_NONE;
                        n_fill  = 2'd2;
                        n_shift = 1'b1;
                    end
                end
                default: begin
                    n_mode = MODE_CUT;
                    if (i_last) begin
                        n_fill = 2'd0;
                    end else begin
                        n_fill  = 2'd2;
                        n_shift = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= 2'd0;
            r_p_valid   <= 1'b0;
            r_step      <= 2'd0;
            r_out_valid <= 1'b0;
        end else begin
            // an unused pass stays empty
            if (!i_enable) begin
                r_fill <= 2'd0;
            end else if (accept) begin
                r_fill <= n_fill;
            end
            if (accept) begin
                r_p_valid <= 1'b1;
            end else if (p_done) begin
                r_p_valid <= 1'b0;
            end
            if (load) begin
                r_step <= emit_final ? 2'd0 : r_step + 2'd1;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mode    <= n_mode;
            r_pt      <= i_point;
            r_pt_last <= i_last;
            r_cv      <= r_curr;
            for (int k = 0; k < NUM_AXES; k++) begin
                r_prod_a[k] <= cut_prod(r_prev[k], r_curr[k]);
                r_prod_b[k] <= cut_prod(i_point[k], r_curr[k]);
            end
            if (i_enable && (r_fill == 2'd0)) begin
                r_curr <= i_point;
            end else if (n_shift) begin
                r_prev <= r_curr;
                r_curr <= i_point;
            end
        end
        if (load) begin
            r_out_point <= emit_pt;
            r_out_last  <= emit_last;
        end
    end

    assign o_valid = r_out_valid;
    assign o_point = r_out_point;
    assign o_last  = r_out_last;

endmodule

### sv/path_corner_smoother.sv
// ----------------------------------------------------------------------------
// path_corner_smoother - streaming corner cutting of a 3D path
// Channel  Dir  Handshake                      Payload
// s_axis   in   s_axis_tvalid/s_axis_tready    point x,y,z; tlast = end of path
// m_axis   out  m_axis_tvalid/m_axis_tready    smoothed x,y,z; tlast = path done
// cfg      in   i_cfg_valid/o_cfg_ready        smoothing pass count
//
// A row of pass cells, one per pass; a cell takes a new point as it emits the
// last point for the one before: two for an interior point, three at path end.
// Two passes turn an ordinary input point into four outputs, one per cycle
// while m_axis_tready is high. Reset is synchronous and empties every window;
// output stalls back up the row through the cell output registers. The user
// must write the pass count only when idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module path_corner_smoother
    import pcs_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [DATA_W-1:0] s_axis_tdata,   // point_x, point_y, point_z
    input  logic              s_axis_tlast,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,   // smooth_x, smooth_y, smooth_z
    output logic              m_axis_tlast,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    logic [PASS_W-1:0] r_passes;

    t_point w_point [MAX_PASSES+1];
    logic   w_valid [MAX_PASSES+1];
    logic   w_ready [MAX_PASSES+1];
    logic   w_last  [MAX_PASSES+1];

    assign o_cfg_ready = 1'b1;

    // saturate the count at the number of cells
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_passes <= PASS_W'(MAX_PASSES);
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (int'(i_cfg_data) > MAX_PASSES) begin
                r_passes <= PASS_W'(MAX_PASSES);
            end else begin
                r_passes <= PASS_W'(i_cfg_data);
            end
        end
    end

    assign w_point[0]    = s_axis_tdata[NUM_AXES*COORD_BITS-1:0];
    assign w_valid[0]    = s_axis_tvalid;
    assign w_last[0]     = s_axis_tlast;
    assign s_axis_tready = w_ready[0];

    for (genvar s = 0; s < MAX_PASSES; s++) begin : g_cell
        pcs_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_enable (r_passes > PASS_W'(s)),
            .i_valid  (w_valid[s]),
            .o_ready  (w_ready[s]),
            .i_point  (w_point[s]),
            .i_last   (w_last[s]),
            .o_valid  (w_valid[s+1]),
            .i_ready  (w_ready[s+1]),
            .o_point  (w_point[s+1]),
            .o_last   (w_last[s+1])
        );
    end

    assign m_axis_tvalid          = w_valid[MAX_PASSES];
    assign w_ready[MAX_PASSES]    = m_axis_tready;
    assign m_axis_tdata           = DATA_W'(w_point[MAX_PASSES]);
    assign m_axis_tlast           = w_last[MAX_PASSES];

endmodule
